// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== sv/mcd_pkg.sv =====
// ---------------------------------------------------------------------------
// mcd_pkg
// Types and constants of the mouse counter delta and button event block.
// ---------------------------------------------------------------------------
`default_nettype none

package mcd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 4;

    // Event kinds
    localparam logic [1:0] KIND_MOTION  = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // Button identifiers
    localparam logic [1:0] BTN_NONE   = 2'd0;
    localparam logic [1:0] BTN_LEFT   = 2'd1;
    localparam logic [1:0] BTN_RIGHT  = 2'd2;
    localparam logic [1:0] BTN_MIDDLE = 2'd3;

    // Event mask bit positions, in emit order
    localparam int EV_MOTION = 0;
    localparam int EV_LEFT   = 1;
    localparam int EV_RIGHT  = 2;
    localparam int EV_MIDDLE = 3;

    // Button line positions (port 0; port 1 is offset)
    localparam int CIA_LEFT_BIT   = 6;
    localparam int POT_RIGHT_BIT  = 10;
    localparam int POT_MIDDLE_BIT = 8;
    localparam int POT_PORT_STEP  = 4;

    // One classified tick waiting to be played out as events
    typedef struct packed {
        logic [7:0] dx;
        logic [7:0] dy;
        logic [3:0] ev_mask;   // bit0 motion, bit1 left, bit2 right, bit3 middle
        logic [2:0] pressed;   // bit0 left, bit1 right, bit2 middle
    } task_t;

    typedef struct packed {
        logic primed;
        logic push;
    } front_status_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== sv/mouse_counter_delta_and_button_events.sv =====
// ---------------------------------------------------------------------------
// mouse_counter_delta_and_button_events
// Mouse counter deltas and button press/release events, one word per event.
// ---------------------------------------------------------------------------
// Usage:
//   s_* takes one snapshot word per frame tick: both counter words, the pot
//   word and the port A byte. cfg_* writes port_select (always ready); write
//   it only while the block is idle.
//   m_* gives up to four event words per tick: motion first, then left,
//   right, middle button changes. tlast marks the final word of a tick;
//   a tick with no motion and no button change gives no word at all.
//   The first event word of a tick passes through the task queue, the task
//   register and the output register before it is valid on m_*.
//   Throughput: the front takes one snapshot per cycle while the task queue
//   (QUEUE_DEPTH entries) has room; the back sends one event word per cycle
//   while m_tready is high, one word for each event of a tick (at most four).
//   When m_tready is low the output register holds its word, the back
//   stalls, the queue fills and then s_tready drops.
//   Reset clears the queue, the output and the stored counter and buttons;
//   the first snapshot after reset only captures the counter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mouse_counter_delta_and_button_events #(
    parameter int QUEUE_DEPTH = mcd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_data,    // port_select
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // port0_counter[15:0], port1_counter[31:16], pot_lines[47:32], cia_lines[55:48]
    input  wire logic [mcd_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // delta_x[7:0], delta_y[15:8]
    output logic [mcd_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // event_kind[1:0], button_id[3:2]
    output logic [mcd_pkg::OUT_TUSER_W-1:0]      m_tuser,
    output logic                                 m_tlast      // last_event
);
    import mcd_pkg::*;

    logic           port_select_reg;
    task_t          push_task, head_task;
    front_status_t  front_status;
    queue_status_t  queue_status;
    logic           pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            port_select_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            port_select_reg <= cfg_data;
    end

    mcd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .port_select (port_select_reg),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .queue_full  (queue_status.full),
        .s_tready    (s_tready),
        .push_task   (push_task),
        .status      (front_status)
    );

    mcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_status.push),
        .push_task (push_task),
        .pop       (pop),
        .head_task (head_task),
        .status    (queue_status)
    );

    mcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_task   (head_task),
        .queue_empty (queue_status.empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // no event can exist before the first snapshot primes the counter
    `ASSERT_CLK(a_no_event_unprimed, clk, rst_n, !front_status.primed |-> !m_tvalid && queue_status.empty, "event before first snapshot")
    // the back never pops an empty queue
    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && queue_status.empty, "pop from empty queue")
    // motion words never name a button
    `ASSERT_CLK(a_motion_no_button, clk, rst_n, m_tvalid && (m_tuser[1:0] == KIND_MOTION) |-> m_tuser[3:2] == BTN_NONE, "motion word with button id")

endmodule

`default_nettype wire

// ===== sv/mcd_front.sv =====
// ---------------------------------------------------------------------------
// mcd_front
// Accepts snapshot words, computes deltas and button changes, queues tasks.
// ---------------------------------------------------------------------------
`default_nettype none

module mcd_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        port_select,
    input  wire logic                        s_tvalid,
    input  wire logic [mcd_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                        queue_full,
    output logic                             s_tready,
    output mcd_pkg::task_t                   push_task,
    output mcd_pkg::front_status_t           status
);
    import mcd_pkg::*;

    logic [15:0] prev_counter_reg, prev_counter_next;
    logic [2:0]  prev_buttons_reg, prev_buttons_next;
    logic        primed_reg, primed_next;

    logic [15:0] port0_counter, port1_counter, pot_lines, counter;
    logic [7:0]  cia_lines;
    logic [2:0]  buttons;
    logic [7:0]  dx, dy;
    logic        accept;

    assign port0_counter = s_tdata[15:0];
    assign port1_counter = s_tdata[31:16];
    assign pot_lines     = s_tdata[47:32];
    assign cia_lines     = s_tdata[55:48];

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        counter = port_select ? port1_counter : port0_counter;
        dx = counter[7:0] - prev_counter_reg[7:0];
        dy = counter[15:8] - prev_counter_reg[15:8];
        // lines are active low
        if (port_select)
        begin
            buttons[0] = !cia_lines[CIA_LEFT_BIT + 1];
            buttons[1] = !pot_lines[POT_RIGHT_BIT + POT_PORT_STEP];
            buttons[2] = !pot_lines[POT_MIDDLE_BIT + POT_PORT_STEP];
        end
        else
        begin
            buttons[0] = !cia_lines[CIA_LEFT_BIT];
            buttons[1] = !pot_lines[POT_RIGHT_BIT];
            buttons[2] = !pot_lines[POT_MIDDLE_BIT];
        end
    end

    always_comb
    begin
        push_task.dx      = dx;
        push_task.dy      = dy;
        push_task.pressed = buttons;
        push_task.ev_mask = {buttons ^ prev_buttons_reg, (dx != 8'd0) || (dy != 8'd0)};
    end

    assign status.primed = primed_reg;
    assign status.push   = accept && primed_reg && (push_task.ev_mask != 4'd0);

    always_comb
    begin
        prev_counter_next = prev_counter_reg;
        prev_buttons_next = prev_buttons_reg;
        primed_next       = primed_reg;
        if (accept)
        begin
            prev_counter_next = counter;
            primed_next       = 1'b1;
            // first word only captures the counter
            if (primed_reg)
                prev_buttons_next = buttons;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_counter_reg <= '0;
            prev_buttons_reg <= '0;
            primed_reg       <= 1'b0;
        end
        else
        begin
            prev_counter_reg <= prev_counter_next;
            prev_buttons_reg <= prev_buttons_next;
            primed_reg       <= primed_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mcd_queue.sv =====
// ---------------------------------------------------------------------------
// mcd_queue
// Short task queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module mcd_queue #(
    parameter int DEPTH = mcd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mcd_pkg::task_t push_task,
    input  wire logic           pop,
    output mcd_pkg::task_t      head_task,
    output mcd_pkg::queue_status_t status
);
    import mcd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] FULL_COUNT = AW'(DEPTH) == '0 ? {1'b1, {AW{1'b0}}}
                                                          : (AW+1)'(DEPTH);

    task_t          entries [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign head_task    = entries[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_task;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mcd_back.sv =====
// ---------------------------------------------------------------------------
// mcd_back
// Plays each queued task out as motion and button event words.
// ---------------------------------------------------------------------------
`default_nettype none

module mcd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mcd_pkg::task_t                head_task,
    input  wire logic                          queue_empty,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [mcd_pkg::OUT_TUSER_W-1:0]    m_tuser,
    output logic                               m_tlast
);
    import mcd_pkg::*;

    task_t       task_reg, task_next;
    logic        task_valid_reg, task_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic [3:0]  out_user_reg, out_user_next;
    logic        out_last_reg, out_last_next;

    logic [3:0]  pick;
    logic [1:0]  kind, button;
    logic        is_last, out_free, emit;

    // lowest pending event goes first
    always_comb
    begin
        pick   = 4'd0;
        kind   = KIND_MOTION;
        button = BTN_NONE;
        priority if (task_reg.ev_mask[EV_MOTION])
        begin
            pick[EV_MOTION] = 1'b1;
        end
        else if (task_reg.ev_mask[EV_LEFT])
        begin
            pick[EV_LEFT] = 1'b1;
            kind   = task_reg.pressed[0] ? KIND_PRESS : KIND_RELEASE;
            button = BTN_LEFT;
        end
        else if (task_reg.ev_mask[EV_RIGHT])
        begin
            pick[EV_RIGHT] = 1'b1;
            kind   = task_reg.pressed[1] ? KIND_PRESS : KIND_RELEASE;
            button = BTN_RIGHT;
        end
        else
        begin
            pick[EV_MIDDLE] = 1'b1;
            kind   = task_reg.pressed[2] ? KIND_PRESS : KIND_RELEASE;
            button = BTN_MIDDLE;
        end
        is_last = (task_reg.ev_mask & ~pick) == 4'd0;
    end

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = task_valid_reg && out_free;
    assign pop      = !queue_empty && (!task_valid_reg || (emit && is_last));

    always_comb
    begin
        task_next       = task_reg;
        task_valid_next = task_valid_reg;
        if (pop)
        begin
            task_next       = head_task;
            task_valid_next = 1'b1;
        end
        else if (emit)
        begin
            task_next.ev_mask = task_reg.ev_mask & ~pick;
            task_valid_next   = !is_last;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {task_reg.dy, task_reg.dx};
            out_user_next  = {button, kind};
            out_last_next  = is_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk)
    begin
        task_reg     <= task_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            task_valid_reg <= task_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== verif/mouse_counter_delta_and_button_events_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mouse_counter_delta_and_button_events_tb
// Drives frame snapshots into the mouse counter block and checks every
// motion and button event word against an in-bench event tracker, with
// random gaps on the snapshot side and random stalls on the event side.
// ---------------------------------------------------------------------------

module mouse_counter_delta_and_button_events_tb;

    import mcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 27;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] button;
        logic [7:0] dx;
        logic [7:0] dy;
        logic       last;
    } mouse_event_t;

    class mouse_event_tracker;
        bit           port_sel;
        bit           primed;
        bit [15:0]    last_counter;
        bit [2:0]     held;          // bit0 left, bit1 right, bit2 middle
        mouse_event_t pending_events[$];
        int           mismatch_count;

        function void take_snapshot(logic [IN_TDATA_W-1:0] word);
            bit [15:0]    counter;
            bit [15:0]    pot;
            bit [7:0]     cia;
            bit [7:0]     dx;
            bit [7:0]     dy;
            bit [2:0]     now_held;
            logic [1:0]   ids [3];
            mouse_event_t ev;
            mouse_event_t tick_events[$];
            ids[0] = BTN_LEFT;
            ids[1] = BTN_RIGHT;
            ids[2] = BTN_MIDDLE;
            counter = port_sel ? word[31:16] : word[15:0];
            pot = word[47:32];
            cia = word[55:48];
            // first tick after reset only captures the counter
            if (!primed)
            begin
                last_counter = counter;
                primed = 1'b1;
                return;
            end
            dx = counter[7:0] - last_counter[7:0];
            dy = counter[15:8] - last_counter[15:8];
            last_counter = counter;
            now_held[0] = !cia[CIA_LEFT_BIT + port_sel];
            now_held[1] = !pot[POT_RIGHT_BIT + POT_PORT_STEP * port_sel];
            now_held[2] = !pot[POT_MIDDLE_BIT + POT_PORT_STEP * port_sel];
            ev.dx = dx;
            ev.dy = dy;
            ev.last = 1'b0;
            if (dx != 0 || dy != 0)
            begin
                ev.kind = KIND_MOTION;
                ev.button = BTN_NONE;
                tick_events.push_back(ev);
            end
            for (int i = 0; i < 3; i++)
            begin
                if (now_held[i] != held[i])
                begin
                    ev.kind = now_held[i] ? KIND_PRESS : KIND_RELEASE;
                    ev.button = ids[i];
                    tick_events.push_back(ev);
                end
            end
            held = now_held;
            if (tick_events.size() > 0)
            begin
                tick_events[tick_events.size() - 1].last = 1'b1;
            end
            foreach (tick_events[k])
            begin
                pending_events.push_back(tick_events[k]);
            end
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void match_event(logic [OUT_TDATA_W-1:0] tdata,
                                  logic [OUT_TUSER_W-1:0] tuser, logic tlast);
            mouse_event_t want;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event word, expected none, got kind %0h button %0h",
                         $time, tuser[1:0], tuser[3:2],
                         " dx %0h dy %0h last %0h", tdata[7:0], tdata[15:8], tlast);
                mismatch_count++;
                return;
            end
            want = pending_events.pop_front();
            check_field("event_kind", want.kind, tuser[1:0]);
            check_field("button_id", want.button, tuser[3:2]);
            check_field("delta_x", want.dx, tdata[7:0]);
            check_field("delta_y", want.dy, tdata[15:8]);
            check_field("last_event", want.last, tlast);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    mouse_event_tracker    tracker = new;
    logic [IN_TDATA_W-1:0] last_word = '0;
    bit                    tx_quiet = 1'b0;
    bit                    rx_quiet = 1'b0;
    int                    idle_cycles = 0;

    mouse_counter_delta_and_button_events i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [IN_TDATA_W-1:0] snap(logic [15:0] c0, logic [15:0] c1,
                                                   logic [15:0] pot, logic [7:0] cia);
        return {cia, pot, c1, c0};
    endfunction

    // Mostly small moves and single button flips, some full noise, some repeats.
    function automatic logic [IN_TDATA_W-1:0] next_random_word(logic [IN_TDATA_W-1:0] prev,
                                                               bit port);
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] pot;
        logic [7:0]  cia;
        int          pick;
        int          idx;
        pick = $urandom_range(0, 9);
        c0 = prev[15:0];
        c1 = prev[31:16];
        pot = prev[47:32];
        cia = prev[55:48];
        if (pick < 3)
        begin
            c0 = 16'($urandom);
            c1 = 16'($urandom);
            pot = 16'($urandom);
            cia = 8'($urandom);
        end
        else if (pick >= 5)
        begin
            c0[7:0] = 8'(c0[7:0] + $urandom_range(0, 6) - 3);
            c0[15:8] = 8'(c0[15:8] + $urandom_range(0, 6) - 3);
            c1[7:0] = 8'(c1[7:0] + $urandom_range(0, 6) - 3);
            c1[15:8] = 8'(c1[15:8] + $urandom_range(0, 6) - 3);
            case ($urandom_range(0, 4))
                0: cia[CIA_LEFT_BIT + port] = ~cia[CIA_LEFT_BIT + port];
                1: pot[POT_RIGHT_BIT + POT_PORT_STEP * port] =
                       ~pot[POT_RIGHT_BIT + POT_PORT_STEP * port];
                2: pot[POT_MIDDLE_BIT + POT_PORT_STEP * port] =
                       ~pot[POT_MIDDLE_BIT + POT_PORT_STEP * port];
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                idx = $urandom_range(0, 15);
                pot[idx] = ~pot[idx];
            end
        end
        return {cia, pot, c1, c0};
    endfunction

    task automatic send_snapshot(input logic [IN_TDATA_W-1:0] word);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do @(posedge clk); while (!s_tready);
        tracker.take_snapshot(word);
        last_word = word;
    endtask

    // Hold the sender until every expected word is out, then let ticks
    // without events drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_port_select(input bit value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.port_sel = value;
    endtask

    // event word receiver
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_quiet ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            tracker.match_event(m_tdata, m_tuser, m_tlast);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_port_select(1'b0);
        // set-up tick, then no change, unit steps and byte wrap extremes
        send_snapshot(snap(16'h1234, 16'hABCD, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'h1234, 16'hABCD, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'h1235, 16'hABCD, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'h1234, 16'hABCD, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'h0000, 16'hABCD, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'hFFFF, 16'hABCD, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'h7F7F, 16'hABCD, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'hFEFE, 16'hABCD, 16'hFFFF, 8'hFF));
        // buttons alone, buttons with motion, full four-event tick
        send_snapshot(snap(16'hFEFE, 16'hABCD, 16'hFFFF, 8'hBF));
        send_snapshot(snap(16'hFEFE, 16'hABCD, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'hFF00, 16'hABCD, 16'hFAFF, 8'hFF));
        send_snapshot(snap(16'hFF01, 16'hABCD, 16'hFFFF, 8'hBF));
        // other port lines and counter move: nothing to report
        send_snapshot(snap(16'hFF01, 16'h0000, 16'hAFFF, 8'h3F));
        wait_idle();

        // delta of the first tick is taken against the other port's counter
        write_port_select(1'b1);
        send_snapshot(snap(16'hFF01, 16'h0102, 16'hAFFF, 8'h3F));
        send_snapshot(snap(16'hFF01, 16'h0102, 16'hAFFF, 8'h3F));
        send_snapshot(snap(16'hFF01, 16'h0102, 16'hFFFF, 8'hFF));
        send_snapshot(snap(16'hFF01, 16'h0000, 16'hFFFF, 8'h7F));
        send_snapshot(snap(16'h5555, 16'hFFFF, 16'h5555, 8'hFF));
        send_snapshot(snap(16'h0000, 16'h8080, 16'h0000, 8'h00));
        send_snapshot(snap(16'h0000, 16'h8080, 16'hFFFF, 8'hFF));
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_port_select(phase[0]);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_snapshot(next_random_word(last_word, tracker.port_sel));
            end
            wait_idle();
        end

        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.pending_events.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== mouse_counter_delta_and_button_events.f =====
+incdir+sv
sv/mcd_pkg.sv
sv/mcd_front.sv
sv/mcd_queue.sv
sv/mcd_back.sv
sv/mouse_counter_delta_and_button_events.sv
verif/mouse_counter_delta_and_button_events_tb.sv
